/* rtl/core/esvs_pkg.sv */
package esvs_pkg;

    // Field widths of the raw encoder word and of the results.
    localparam int RAW_W = 16;
    localparam int POS_W = 14;
    localparam int ERR_W = 16;
    localparam int STATUS_W = 2;

    // Status code that marks a good word, and the highest position a good word may carry.
    localparam logic [STATUS_W-1:0] STATUS_VALID = 2'b01;
    localparam logic [POS_W-1:0]    POS_LIMIT    = 14'd16350;
    localparam logic [POS_W-1:0]    POS_MAX      = {POS_W{1'b1}};
    localparam logic [ERR_W-1:0]    ERR_MAX      = {ERR_W{1'b1}};

    // Defaults for the smoothing ring.
    localparam int SMOOTH_DEPTH_DEFAULT = 8;
    localparam int AVG_SHIFT_DEFAULT    = 3;

    // What one channel reports for the item just taken.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] average;
        logic [ERR_W-1:0] errors;
        logic             bad;
    } chan_result_t;

endpackage

/* rtl/core/esvs_if.sv */
// Input channel: one raw word for each encoder channel.
interface esvs_in_if;
    logic                       valid;
    logic                       ready;
    logic [esvs_pkg::RAW_W-1:0] raw_word_a;
    logic [esvs_pkg::RAW_W-1:0] raw_word_b;

    modport source (output valid, output raw_word_a, output raw_word_b, input ready);
    modport sink   (input valid, input raw_word_a, input raw_word_b, output ready);
endinterface

// Output channel: positions, averages, error counts and bad flags.
interface esvs_out_if;
    logic                       valid;
    logic                       ready;
    logic [esvs_pkg::POS_W-1:0] position_a;
    logic [esvs_pkg::POS_W-1:0] position_b;
    logic [esvs_pkg::POS_W-1:0] average_a;
    logic [esvs_pkg::POS_W-1:0] average_b;
    logic [esvs_pkg::ERR_W-1:0] errors_a;
    logic [esvs_pkg::ERR_W-1:0] errors_b;
    logic                       bad_a;
    logic                       bad_b;

    modport source (
        output valid, input ready,
        output position_a, output position_b, output average_a, output average_b,
        output errors_a, output errors_b, output bad_a, output bad_b
    );
    modport sink (
        input valid, output ready,
        input position_a, input position_b, input average_a, input average_b,
        input errors_a, input errors_b, input bad_a, input bad_b
    );
endinterface

/* rtl/core/esvs_chan.sv */
module esvs_chan #(
    parameter int SMOOTH_DEPTH = esvs_pkg::SMOOTH_DEPTH_DEFAULT,
    parameter int AVG_SHIFT    = esvs_pkg::AVG_SHIFT_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       filter_off,
    input  logic [esvs_pkg::RAW_W-1:0] raw_word,
    output esvs_pkg::chan_result_t     result
);
    import esvs_pkg::*;

    localparam int SUM_W = POS_W + $clog2(SMOOTH_DEPTH);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [ERR_W-1:0] err_reg;
    logic [ERR_W-1:0] err_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [POS_W-1:0] taps_reg [SMOOTH_DEPTH];

    logic [POS_W-1:0] word_pos;
    logic             word_ok;
    logic [SUM_W-1:0] avg_wide;

    // Validity test on the raw word.
    assign word_pos = raw_word[RAW_W-1:STATUS_W];
    assign word_ok  = (raw_word[STATUS_W-1:0] == STATUS_VALID) && (word_pos <= POS_LIMIT);

    // Held position and saturating error count.
    always_comb
    begin
        pos_next = pos_reg;
        err_next = err_reg;
        if (word_ok || filter_off)
        begin
            pos_next = word_pos;
        end
        else if (err_reg != ERR_MAX)
        begin
            err_next = err_reg + ERR_W'(1);
        end
    end

    // Running sum: the oldest entry of the ring leaves, the new position enters.
    assign sum_next = sum_reg - SUM_W'(taps_reg[SMOOTH_DEPTH-1]) + SUM_W'(pos_next);
    assign avg_wide = sum_next >> AVG_SHIFT;

    // Results of this item, with the average saturated to the position range.
    always_comb
    begin
        result.position = pos_next;
        result.errors   = err_next;
        result.bad      = ~word_ok;
        if (avg_wide > SUM_W'(POS_MAX))
        begin
            result.average = POS_MAX;
        end
        else
        begin
            result.average = avg_wide[POS_W-1:0];
        end
    end

    // Channel state and the ring, kept as a shift line so the oldest entry sits at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            err_reg <= '0;
            sum_reg <= '0;
            for (int i = 0; i < SMOOTH_DEPTH; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            sum_reg     <= sum_next;
            taps_reg[0] <= pos_next;
            for (int i = 1; i < SMOOTH_DEPTH; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
    end

endmodule

/* rtl/core/encoder_sample_validate_and_smooth.sv */
// Channel      Direction  Handshake     Contents
// sample_in    in         valid/ready   raw_word_a, raw_word_b
// result_out   out        valid/ready   position, average, errors, bad (A and B)
// cfg          in         cfg_we        cfg_wdata = filter_off
//
// One item per cycle while the result side is not stalled: validation, ring update
// and averaging are combinational from the input ports into the result register.
// Reset clears positions, error counts, running sums, the rings and filter_off.
// An item is taken while the result register is empty or being emptied, so a
// stalled result holds its value and blocks input only for as long as it stalls.
module encoder_sample_validate_and_smooth #(
    parameter int SMOOTH_DEPTH = esvs_pkg::SMOOTH_DEPTH_DEFAULT,
    parameter int AVG_SHIFT    = esvs_pkg::AVG_SHIFT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    esvs_in_if.sink    sample_in,
    esvs_out_if.source result_out
);
    import esvs_pkg::*;

    logic         filter_off_reg;
    logic         out_valid_reg;
    logic         take;
    chan_result_t res_a;
    chan_result_t res_b;
    chan_result_t res_a_reg;
    chan_result_t res_b_reg;

    // Accept an item whenever the result register can be loaded.
    assign sample_in.ready = ~out_valid_reg | result_out.ready;
    assign take            = sample_in.valid & sample_in.ready;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_off_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            filter_off_reg <= cfg_wdata;
        end
    end

    // The two encoder channels.
    esvs_chan #(
        .SMOOTH_DEPTH (SMOOTH_DEPTH),
        .AVG_SHIFT    (AVG_SHIFT)
    ) u_chan_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (take),
        .filter_off (filter_off_reg),
        .raw_word   (sample_in.raw_word_a),
        .result     (res_a)
    );

    esvs_chan #(
        .SMOOTH_DEPTH (SMOOTH_DEPTH),
        .AVG_SHIFT    (AVG_SHIFT)
    ) u_chan_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (take),
        .filter_off (filter_off_reg),
        .raw_word   (sample_in.raw_word_b),
        .result     (res_b)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_a_reg <= res_a;
            res_b_reg <= res_b;
        end
    end

    // Drive the result channel.
    assign result_out.valid      = out_valid_reg;
    assign result_out.position_a = res_a_reg.position;
    assign result_out.position_b = res_b_reg.position;
    assign result_out.average_a  = res_a_reg.average;
    assign result_out.average_b  = res_b_reg.average;
    assign result_out.errors_a   = res_a_reg.errors;
    assign result_out.errors_b   = res_b_reg.errors;
    assign result_out.bad_a      = res_a_reg.bad;
    assign result_out.bad_b      = res_b_reg.bad;

endmodule
